[src/eed_pkg.sv]
// eed_pkg: shared types, character codes and helpers for the echo escape decoder
// no dependencies; imported by every module under src

package eed_pkg;

    // request kinds carried on the input tuser
    localparam logic [1:0] REQ_BYTE     = 2'd0;
    localparam logic [1:0] REQ_BOUNDARY = 2'd1;
    localparam logic [1:0] REQ_END      = 2'd2;
    localparam logic [1:0] REQ_IGNORED  = 2'd3;  // reserved kind, dropped without effect

    // shell dialects
    localparam logic [1:0] MODE_DEFAULT = 2'd0;
    localparam logic [1:0] MODE_COMPAT  = 2'd1;
    localparam logic [1:0] MODE_POSIX   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SHELL_MODE  = 2'd0;
    localparam logic [1:0] CFG_INTERPRET   = 2'd1;
    localparam logic [1:0] CFG_SUPPRESS_NL = 2'd2;

    // widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned CFG_W   = 2;
    localparam int unsigned COUNT_W = 2;

    // character codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_V  = 8'h76;

    // escape decoder phase
    typedef enum logic [1:0] {
        PH_PLAIN     = 2'd0,
        PH_BACKSLASH = 2'd1,
        PH_OCTAL     = 2'd2
    } phase_t;

    // configuration as seen by the decoder
    typedef struct packed {
        logic [1:0] shell_mode;
        logic       interpret_escapes;
        logic       suppress_newline;
    } cfg_t;

    // up to two result bytes produced by one input beat
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  byte0;
        logic [BYTE_W-1:0]  byte1;
    } res_t;

    // append one byte to a result pair, extra bytes are dropped
    function automatic res_t put_byte(res_t r, logic [BYTE_W-1:0] b);
        res_t o;
        o = r;
        if (r.count == 2'd0) begin
            o.byte0 = b;
            o.count = 2'd1;
        end else if (r.count == 2'd1) begin
            o.byte1 = b;
            o.count = 2'd2;
        end
        return o;
    endfunction

endpackage

[src/eed_decoder.sv]
// eed_decoder: escape state registers and the per-beat decode logic
// depends on eed_pkg for codes, cfg_t and res_t

module eed_decoder
    import eed_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  cfg_t                cfg,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [BYTE_W-1:0]   data_byte,
    output res_t                res
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] oval_reg, oval_next;
    logic [1:0]        odig_reg, odig_next;
    logic              stopped_reg, stopped_next;

    logic              is_compat;
    logic              is_posix;
    logic              is_digit;
    logic [BYTE_W-1:0] oval_shift;
    logic [1:0]        odig_dec;

    assign is_compat  = (cfg.shell_mode == MODE_COMPAT);
    assign is_posix   = (cfg.shell_mode == MODE_POSIX);
    assign is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_SEVEN);
    assign oval_shift = {oval_reg[BYTE_W-4:0], data_byte[2:0]};
    assign odig_dec   = (odig_reg != 2'd0) ? odig_reg - 2'd1 : 2'd0;

    // decode one beat into next state and up to two bytes
    always_comb begin
        phase_next   = phase_reg;
        oval_next    = oval_reg;
        odig_next    = odig_reg;
        stopped_next = stopped_reg;
        res          = '0;

        if (req_type == REQ_IGNORED) begin
            // unused request kind: no effect
        end else if (stopped_reg) begin
            if (req_type == REQ_END) begin
                stopped_next = 1'b0;
                phase_next   = PH_PLAIN;
                oval_next    = '0;
                odig_next    = '0;
            end
        end else if (req_type == REQ_BYTE) begin
            case (phase_reg)
                PH_BACKSLASH: begin
                    phase_next = PH_PLAIN;
                    case (data_byte)
                        CH_LO_A: res = put_byte(res, CH_BEL);
                        CH_LO_B: res = put_byte(res, CH_BS);
                        CH_LO_F: res = put_byte(res, CH_FF);
                        CH_LO_N: res = put_byte(res, CH_LF);
                        CH_LO_R: res = put_byte(res, CH_CR);
                        CH_LO_T: res = put_byte(res, CH_TAB);
                        CH_LO_V: res = put_byte(res, CH_VT);
                        CH_LO_E, CH_UP_E: begin
                            if (is_posix) begin
                                res = put_byte(res, CH_BSL);
                                res = put_byte(res, data_byte);
                            end else begin
                                res = put_byte(res, CH_ESC);
                            end
                        end
                        CH_BSL: res = put_byte(res, CH_BSL);
                        CH_LO_C: stopped_next = 1'b1;
                        CH_ZERO: begin
                            phase_next = PH_OCTAL;
                            oval_next  = '0;
                            odig_next  = 2'd3;
                        end
                        default: begin
                            if (data_byte >= CH_ONE && data_byte <= CH_SEVEN
                                && !is_compat) begin
                                phase_next = PH_OCTAL;
                                oval_next  = {5'd0, data_byte[2:0]};
                                odig_next  = 2'd2;
                            end else begin
                                res = put_byte(res, CH_BSL);
                                res = put_byte(res, data_byte);
                            end
                        end
                    endcase
                end
                PH_OCTAL: begin
                    if (is_digit) begin
                        oval_next = oval_shift;
                        odig_next = odig_dec;
                        if (odig_dec == 2'd0) begin
                            res        = put_byte(res, oval_shift);
                            phase_next = PH_PLAIN;
                            oval_next  = '0;
                        end
                    end else begin
                        // octal run ended by another byte, which is then decoded as in the plain phase
                        res        = put_byte(res, oval_reg);
                        phase_next = PH_PLAIN;
                        oval_next  = '0;
                        odig_next  = '0;
                        if (cfg.interpret_escapes && data_byte == CH_BSL) begin
                            phase_next = PH_BACKSLASH;
                        end else begin
                            res = put_byte(res, data_byte);
                        end
                    end
                end
                default: begin
                    phase_next = PH_PLAIN;
                    if (cfg.interpret_escapes && data_byte == CH_BSL) begin
                        phase_next = PH_BACKSLASH;
                    end else begin
                        res = put_byte(res, data_byte);
                    end
                end
            endcase
        end else begin
            // flush a cut-off escape, then space, or newline unless suppressed
            if (phase_reg == PH_BACKSLASH) begin
                res = put_byte(res, CH_BSL);
            end else if (phase_reg == PH_OCTAL) begin
                res = put_byte(res, oval_reg);
            end
            phase_next = PH_PLAIN;
            oval_next  = '0;
            odig_next  = '0;
            if (req_type == REQ_BOUNDARY) begin
                res = put_byte(res, CH_SPACE);
            end else begin
                if (!cfg.suppress_newline) begin
                    res = put_byte(res, CH_LF);
                end
                stopped_next = 1'b0;
            end
        end
    end

    // escape state, updated on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_PLAIN;
            oval_reg    <= '0;
            odig_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            oval_reg    <= oval_next;
            odig_reg    <= odig_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

[src/eed_out_buf.sv]
// eed_out_buf: result register holding up to two bytes, drained one beat per cycle while m_tready is high
// depends on eed_pkg for res_t

module eed_out_buf
    import eed_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  res_t              res,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast
);

    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [BYTE_W-1:0]  b0_reg, b0_next;
    logic [BYTE_W-1:0]  b1_reg, b1_next;
    logic               deliver;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = b0_reg;
    assign m_tlast  = (cnt_reg == 2'd1);
    assign deliver  = m_tvalid && m_tready;
    // room for a new pair once the last pending byte leaves this cycle
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    // next contents of the result register
    always_comb begin
        cnt_next = cnt_reg;
        b0_next  = b0_reg;
        b1_next  = b1_reg;
        if (load) begin
            cnt_next = res.count;
            b0_next  = res.byte0;
            b1_next  = res.byte1;
        end else if (deliver) begin
            cnt_next = cnt_reg - 2'd1;
            b0_next  = b1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        b0_reg <= b0_next;
        b1_reg <= b1_next;
    end

endmodule

[src/echo_escape_decoder_core.sv]
// echo_escape_decoder_core: top level of the echo escape decoder
// depends on eed_pkg, eed_decoder and eed_out_buf
//
// Usage:
//   s_ channel: one beat per request; s_tuser is the request kind (argument
//   byte, argument boundary, command end), s_tdata the argument byte.
//   m_ channel: decoded bytes on m_tdata; m_tlast marks the last byte
//   produced by one input beat. A beat may produce zero, one or two bytes.
//   cfg_ port: write shell_mode (index 0), interpret_escapes (index 1) and
//   suppress_newline (index 2) only while the block is idle.
// Output: the first byte of a beat shows on m_ in the cycle after acceptance.
// Throughput: one input beat per cycle while m_tready is high and each beat
//   yields at most one byte; a beat yielding two bytes holds the result
//   register until both have left, the output port being one byte wide.
// Reset: aresetn low clears the escape state and the result register and
//   restores the configuration defaults (default dialect, escapes decoded,
//   newline emitted).
// Stall: with m_tready low, pending bytes hold in the result register and
//   s_tready drops once no room is left for the next beat's bytes.

module echo_escape_decoder_core
    import eed_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic [REQ_W-1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast
);

    cfg_t cfg_reg;
    res_t res;
    logic accept;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shell_mode        <= MODE_DEFAULT;
            cfg_reg.interpret_escapes <= 1'b1;
            cfg_reg.suppress_newline  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SHELL_MODE:  cfg_reg.shell_mode        <= cfg_wr_data;
                CFG_INTERPRET:   cfg_reg.interpret_escapes <= cfg_wr_data[0];
                CFG_SUPPRESS_NL: cfg_reg.suppress_newline  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    // escape decode and state
    eed_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cfg       (cfg_reg),
        .req_type  (s_tuser),
        .data_byte (s_tdata),
        .res       (res)
    );

    // result register and output beat sequencing
    eed_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res      (res),
        .can_load (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
